[hdl/triangle_normal_centroid_unit_defines.svh]
// Assertion macros for the triangle normal and centroid unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TRIANGLE_NORMAL_CENTROID_UNIT_DEFINES_SVH
`define TRIANGLE_NORMAL_CENTROID_UNIT_DEFINES_SVH

// same-cycle implication
`define TNC_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("triangle unit check failed");

// next-cycle implication
`define TNC_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("triangle unit check failed");

`endif

[hdl/tnc_pkg.sv]
// Shared widths, constants and carry types for the triangle unit.
// No dependencies.
package tnc_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = 17;
    localparam int SUM_W     = 18;
    localparam int PROD_W    = 34;
    localparam int CROSS_W   = 35;
    localparam int MAG_W     = 34;
    localparam int NORM_W    = 31;
    localparam int SQ_W      = 62;
    localparam int SSUM_W    = 64;
    localparam int LEN_W     = 32;
    localparam int QUO_W     = 16;
    localparam int NUM_W     = 48;
    localparam int CABS_W    = 17;
    localparam int CPROD_W   = 33;
    localparam int RECIP_SH  = 17;
    localparam int NORM_TOP  = 30;
    localparam int SQRT_ITER = 32;
    localparam int DIV_ITER  = 16;
    localparam int FRAC_SH   = 15;

    localparam int SQRT_STEPS_DEFAULT = 2;
    localparam int DIV_STEPS_DEFAULT  = 2;

    // ceil(2^17 / 3): exact floor(x / 3) for x < 2^17
    localparam logic [15:0] RECIP3 = 16'd43691;

    localparam logic [QUO_W-1:0] Q15_MAX = 16'd32767;
    localparam logic [QUO_W-1:0] Q15_ONE = 16'd32768;

    typedef struct packed {
        logic [2:0]                 neg;
        logic                       degen;
        logic [2:0][COORD_W-1:0]    cent;
    } side_t;

    typedef struct packed {
        side_t                      side;
        logic [2:0][NORM_W-1:0]     mag;
    } carry_t;

endpackage

[hdl/tnc_front.sv]
// Front pipeline: edge vectors, cross product, centroid, scaling and squares.
// Depends on tnc_pkg.
module tnc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                vld_in,
    input  logic [2:0][tnc_pkg::COORD_W-1:0]    va,
    input  logic [2:0][tnc_pkg::COORD_W-1:0]    vb,
    input  logic [2:0][tnc_pkg::COORD_W-1:0]    vc,
    output logic                                vld_out,
    output logic [tnc_pkg::SSUM_W-1:0]          ssum,
    output tnc_pkg::carry_t                     carry
);

    localparam int DW  = tnc_pkg::DIFF_W;
    localparam int SW  = tnc_pkg::SUM_W;
    localparam int PW  = tnc_pkg::PROD_W;
    localparam int CW  = tnc_pkg::CROSS_W;
    localparam int MW  = tnc_pkg::MAG_W;
    localparam int NW  = tnc_pkg::NORM_W;
    localparam int QW  = tnc_pkg::SQ_W;
    localparam int TW  = tnc_pkg::SSUM_W;
    localparam int AW  = tnc_pkg::CABS_W;
    localparam int RW  = tnc_pkg::CPROD_W;
    localparam int XW  = tnc_pkg::COORD_W;
    localparam int RSH = tnc_pkg::RECIP_SH;

    logic [8:0] vld_reg;

    // stage 1
    logic signed [DW-1:0] u_reg [3], u_next [3];
    logic signed [DW-1:0] v_reg [3], v_next [3];
    logic signed [SW-1:0] sum_reg [3], sum_next [3];
    // stage 2
    logic signed [PW-1:0] pa_reg [3], pa_next [3];
    logic signed [PW-1:0] pb_reg [3], pb_next [3];
    logic [RW-1:0]        cprod_reg [3], cprod_next [3];
    logic [2:0]           cneg_reg, cneg_next;
    // stage 3
    logic signed [CW-1:0] cross_reg [3], cross_next [3];
    tnc_pkg::side_t       side3_reg, side3_next;
    // stage 4
    logic [MW-1:0]        mag4_reg [3], mag4_next [3];
    tnc_pkg::side_t       side4_reg, side4_next;
    // stage 5
    logic [MW-1:0]        mag5_reg [3];
    logic [MW-1:0]        big_reg, big_next;
    tnc_pkg::side_t       side5_reg;
    // stage 6
    logic [MW-1:0]        mag6_reg [3];
    logic [5:0]           sh_reg, sh_next;
    logic                 left_reg, left_next;
    tnc_pkg::side_t       side6_reg, side6_next;
    // stages 7 to 9
    tnc_pkg::carry_t      carry7_reg, carry7_next;
    logic [QW-1:0]        sq_reg [3], sq_next [3];
    tnc_pkg::carry_t      carry8_reg;
    logic [TW-1:0]        ssum_reg, ssum_next;
    tnc_pkg::carry_t      carry9_reg;

    logic [SW-1:0] cabs;
    logic [AW-1:0] cx;
    logic [MW-1:0] m01;
    logic [5:0]    msb;
    logic [MW-1:0] shv;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u_next[k]   = DW'($signed(vb[k])) - DW'($signed(va[k]));
            v_next[k]   = DW'($signed(vc[k])) - DW'($signed(va[k]));
            sum_next[k] = SW'($signed(va[k])) + SW'($signed(vb[k])) + SW'($signed(vc[k]));
        end
    end

    // cross terms and centroid reciprocal multiply
    always_comb
    begin
        cabs = '0;
        cx   = '0;
        for (int k = 0; k < 3; k++)
        begin
            pa_next[k]   = PW'(u_reg[(k + 1) % 3]) * PW'(v_reg[(k + 2) % 3]);
            pb_next[k]   = PW'(u_reg[(k + 2) % 3]) * PW'(v_reg[(k + 1) % 3]);
            cneg_next[k] = sum_reg[k][SW-1];
            cabs         = cneg_next[k] ? SW'(-sum_reg[k]) : SW'(sum_reg[k]);
            cx           = AW'(cabs) + AW'(1);
            cprod_next[k] = RW'(cx) * RW'(tnc_pkg::RECIP3);
        end
    end

    always_comb
    begin
        side3_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            cross_next[k] = CW'(pa_reg[k]) - CW'(pb_reg[k]);
            side3_next.cent[k] = cneg_reg[k] ? (XW'(0) - cprod_reg[k][RW-1:RSH])
                                             : cprod_reg[k][RW-1:RSH];
        end
    end

    always_comb
    begin
        side4_next = side3_reg;
        for (int k = 0; k < 3; k++)
        begin
            side4_next.neg[k] = cross_reg[k][CW-1];
            mag4_next[k] = cross_reg[k][CW-1] ? MW'(-cross_reg[k]) : MW'(cross_reg[k]);
        end
    end

    always_comb
    begin
        m01      = (mag4_reg[0] > mag4_reg[1]) ? mag4_reg[0] : mag4_reg[1];
        big_next = (m01 > mag4_reg[2]) ? m01 : mag4_reg[2];
    end

    // leading one of the largest magnitude sets the common shift
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (big_reg[i])
            begin
                msb = 6'(i);
            end
        end
        side6_next       = side5_reg;
        side6_next.degen = (big_reg == '0);
        left_next        = (msb < 6'(tnc_pkg::NORM_TOP));
        sh_next          = left_next ? (6'(tnc_pkg::NORM_TOP) - msb)
                                     : (msb - 6'(tnc_pkg::NORM_TOP));
    end

    always_comb
    begin
        shv = '0;
        carry7_next.side = side6_reg;
        for (int k = 0; k < 3; k++)
        begin
            shv = left_reg ? (mag6_reg[k] << sh_reg) : (mag6_reg[k] >> sh_reg);
            carry7_next.mag[k] = shv[NW-1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_next[k] = QW'(carry7_reg.mag[k]) * QW'(carry7_reg.mag[k]);
        end
        ssum_next = TW'(sq_reg[0]) + TW'(sq_reg[1]) + TW'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[7:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg      <= u_next;
            v_reg      <= v_next;
            sum_reg    <= sum_next;
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            cprod_reg  <= cprod_next;
            cneg_reg   <= cneg_next;
            cross_reg  <= cross_next;
            side3_reg  <= side3_next;
            mag4_reg   <= mag4_next;
            side4_reg  <= side4_next;
            mag5_reg   <= mag4_reg;
            big_reg    <= big_next;
            side5_reg  <= side4_reg;
            mag6_reg   <= mag5_reg;
            sh_reg     <= sh_next;
            left_reg   <= left_next;
            side6_reg  <= side6_next;
            carry7_reg <= carry7_next;
            sq_reg     <= sq_next;
            carry8_reg <= carry7_reg;
            ssum_reg   <= ssum_next;
            carry9_reg <= carry8_reg;
        end
    end

    assign vld_out = vld_reg[8];
    assign ssum    = ssum_reg;
    assign carry   = carry9_reg;

endmodule

[hdl/tnc_sqrt.sv]
// Pipelined bitwise integer square root, a few result bits per stage.
// Depends on tnc_pkg.
module tnc_sqrt #(
    parameter int STEPS = tnc_pkg::SQRT_STEPS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        vld_in,
    input  logic [tnc_pkg::SSUM_W-1:0]  ssum,
    input  tnc_pkg::carry_t             carry_in,
    output logic                        vld_out,
    output logic [tnc_pkg::LEN_W-1:0]   len,
    output tnc_pkg::carry_t             carry_out
);

    localparam int TW   = tnc_pkg::SSUM_W;
    localparam int NSTG = tnc_pkg::SQRT_ITER / STEPS;

    logic [NSTG-1:0]  vld_reg;
    logic [TW-1:0]    rem_reg [NSTG];
    logic [TW-1:0]    res_reg [NSTG];
    tnc_pkg::carry_t  carry_reg [NSTG];

    for (genvar g = 0; g < NSTG; g++)
    begin : g_stage
        logic [TW-1:0]   rem_in, res_in, rem_next, res_next, trial;
        tnc_pkg::carry_t c_in;

        if (g == 0)
        begin : g_first
            assign rem_in = ssum;
            assign res_in = '0;
            assign c_in   = carry_in;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign res_in = res_reg[g-1];
            assign c_in   = carry_reg[g-1];
        end

        always_comb
        begin
            rem_next = rem_in;
            res_next = res_in;
            trial    = '0;
            for (int j = 0; j < STEPS; j++)
            begin
                trial = res_next + (TW'(1) << (TW - 2 - 2 * (g * STEPS + j)));
                if (rem_next >= trial)
                begin
                    rem_next = rem_next - trial;
                    res_next = (res_next >> 1) + (TW'(1) << (TW - 2 - 2 * (g * STEPS + j)));
                end
                else
                begin
                    res_next = res_next >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]   <= rem_next;
                res_reg[g]   <= res_next;
                carry_reg[g] <= c_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], vld_in};
        end
    end

    assign vld_out   = vld_reg[NSTG-1];
    assign len       = res_reg[NSTG-1][tnc_pkg::LEN_W-1:0];
    assign carry_out = carry_reg[NSTG-1];

endmodule

[hdl/tnc_div.sv]
// Three-lane pipelined restoring divider: rounded m * 2^15 / len.
// Depends on tnc_pkg.
module tnc_div #(
    parameter int STEPS = tnc_pkg::DIV_STEPS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                vld_in,
    input  logic [tnc_pkg::LEN_W-1:0]           len,
    input  tnc_pkg::carry_t                     carry_in,
    output logic                                vld_out,
    output logic [2:0][tnc_pkg::QUO_W-1:0]      quo,
    output tnc_pkg::side_t                      side_out
);

    localparam int UW   = tnc_pkg::NUM_W;
    localparam int LW   = tnc_pkg::LEN_W;
    localparam int QW   = tnc_pkg::QUO_W;
    localparam int NSTG = tnc_pkg::DIV_ITER / STEPS;

    logic [NSTG:0]            vld_reg;
    logic [2:0][UW-1:0]       num_reg;
    logic [LW-1:0]            len_reg [NSTG+1];
    tnc_pkg::side_t           side_reg [NSTG+1];
    logic [2:0][UW-1:0]       rem_reg [NSTG];
    logic [2:0][QW-1:0]       q_reg [NSTG];
    logic [2:0][UW-1:0]       num_next;

    // numerator with half the divisor added for round to nearest
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            num_next[k] = (UW'(carry_in.mag[k]) << tnc_pkg::FRAC_SH) + UW'(len >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg     <= num_next;
            len_reg[0]  <= len;
            side_reg[0] <= carry_in.side;
        end
    end

    for (genvar g = 0; g < NSTG; g++)
    begin : g_stage
        logic [2:0][UW-1:0] rem_in, rem_next;
        logic [2:0][QW-1:0] q_in, q_next;
        logic [UW-1:0]      trial;

        if (g == 0)
        begin : g_first
            assign rem_in = num_reg;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign q_in   = q_reg[g-1];
        end

        always_comb
        begin
            rem_next = rem_in;
            q_next   = q_in;
            trial    = '0;
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < STEPS; j++)
                begin
                    trial = UW'(len_reg[g]) << (QW - 1 - (g * STEPS + j));
                    if (rem_next[k] >= trial)
                    begin
                        rem_next[k] = rem_next[k] - trial;
                        q_next[k][QW - 1 - (g * STEPS + j)] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]    <= rem_next;
                q_reg[g]      <= q_next;
                len_reg[g+1]  <= len_reg[g];
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-1:0], vld_in};
        end
    end

    assign vld_out  = vld_reg[NSTG];
    assign quo      = q_reg[NSTG-1];
    assign side_out = side_reg[NSTG];

endmodule

[hdl/triangle_normal_centroid_unit.sv]
// Triangle unit normal and centroid, top level.
// Depends on tnc_pkg, tnc_front, tnc_sqrt, tnc_div and the assertion macro header.
//
// Takes one triangle (three Q8.8 vertices) per cycle while in_ready is high
// and returns its rounded centroid and its unit face normal in Q1.15
// (saturated at +1.0), with a degenerate flag and a zero normal when the
// cross product is zero. Fully pipelined: one item enters and one leaves
// every cycle unless the output stalls. The square root and divider resolve
// SQRT_STEPS and DIV_STEPS result bits per stage and set the depth. A full
// stop of the output stalls every stage at once; in_ready is low only while
// a result sits in the output register and out_ready is low. No
// configuration, no state kept between items.
`include "triangle_normal_centroid_unit_defines.svh"

module triangle_normal_centroid_unit #(
    parameter int SQRT_STEPS = tnc_pkg::SQRT_STEPS_DEFAULT,
    parameter int DIV_STEPS  = tnc_pkg::DIV_STEPS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  ax,
    input  logic signed [15:0]  ay,
    input  logic signed [15:0]  az,
    input  logic signed [15:0]  bx,
    input  logic signed [15:0]  by,
    input  logic signed [15:0]  bz,
    input  logic signed [15:0]  cx,
    input  logic signed [15:0]  cy,
    input  logic signed [15:0]  cz,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  normal_x,
    output logic signed [15:0]  normal_y,
    output logic signed [15:0]  normal_z,
    output logic signed [15:0]  centroid_x,
    output logic signed [15:0]  centroid_y,
    output logic signed [15:0]  centroid_z,
    output logic                degenerate
);

    localparam int QW = tnc_pkg::QUO_W;

    // global advance: the whole pipe moves unless the output is held
    logic en;

    logic [2:0][tnc_pkg::COORD_W-1:0] va, vb, vc;

    logic                          fr_vld;
    logic [tnc_pkg::SSUM_W-1:0]    fr_ssum;
    tnc_pkg::carry_t               fr_carry;

    logic                          sq_vld;
    logic [tnc_pkg::LEN_W-1:0]     sq_len;
    tnc_pkg::carry_t               sq_carry;

    logic                          div_vld;
    logic [2:0][QW-1:0]            div_q;
    tnc_pkg::side_t                div_side;

    logic                          vld_reg;
    logic [2:0][QW-1:0]            nrm_reg, nrm_next;
    logic [2:0][QW-1:0]            cent_reg;
    logic                          degen_reg;

    assign en       = !vld_reg || out_ready;
    assign in_ready = en;

    assign va = {az, ay, ax};
    assign vb = {bz, by, bx};
    assign vc = {cz, cy, cx};

    tnc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (in_valid),
        .va      (va),
        .vb      (vb),
        .vc      (vc),
        .vld_out (fr_vld),
        .ssum    (fr_ssum),
        .carry   (fr_carry)
    );

    tnc_sqrt #(
        .STEPS (SQRT_STEPS)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vld_in    (fr_vld),
        .ssum      (fr_ssum),
        .carry_in  (fr_carry),
        .vld_out   (sq_vld),
        .len       (sq_len),
        .carry_out (sq_carry)
    );

    tnc_div #(
        .STEPS (DIV_STEPS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (sq_vld),
        .len      (sq_len),
        .carry_in (sq_carry),
        .vld_out  (div_vld),
        .quo      (div_q),
        .side_out (div_side)
    );

    // sign and saturation: +1.0 clips to 32767, -1.0 is exact
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (div_side.degen)
            begin
                nrm_next[k] = '0;
            end
            else if (div_side.neg[k])
            begin
                nrm_next[k] = (div_q[k] > tnc_pkg::Q15_ONE) ? tnc_pkg::Q15_ONE
                                                            : (QW'(0) - div_q[k]);
            end
            else
            begin
                nrm_next[k] = (div_q[k] > tnc_pkg::Q15_MAX) ? tnc_pkg::Q15_MAX : div_q[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nrm_reg   <= nrm_next;
            cent_reg  <= div_side.cent;
            degen_reg <= div_side.degen;
        end
    end

    assign out_valid  = vld_reg;
    assign normal_x   = nrm_reg[0];
    assign normal_y   = nrm_reg[1];
    assign normal_z   = nrm_reg[2];
    assign centroid_x = cent_reg[0];
    assign centroid_y = cent_reg[1];
    assign centroid_z = cent_reg[2];
    assign degenerate = degen_reg;

    // a degenerate item carries a zero normal
    `TNC_ASSERT_NOW(a_degen_zero, out_valid && degenerate, normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0)
    // a unit vector has one component of at least 1/sqrt(3)
    `TNC_ASSERT_NOW(a_unit_len, out_valid && !degenerate, normal_x >= 16'sd18000 || normal_x <= -16'sd18000 || normal_y >= 16'sd18000 || normal_y <= -16'sd18000 || normal_z >= 16'sd18000 || normal_z <= -16'sd18000)
    // quotients never exceed 1.0 for a non-degenerate item
    `TNC_ASSERT_NOW(a_quo_range, div_vld && !div_side.degen, div_q[0] <= tnc_pkg::Q15_ONE && div_q[1] <= tnc_pkg::Q15_ONE && div_q[2] <= tnc_pkg::Q15_ONE)
    // a degenerate item leaving the divider shows up at the output
    `TNC_ASSERT_NEXT(a_degen_flow, en && div_vld && div_side.degen, out_valid && degenerate)

endmodule
